### hw/rtl/ifk_pkg.sv
// ----------------------------------------------------------------------------
// ifk_pkg: shared types and constants of the indenter force kernel
// Fixed formats, register codes, the front/back item, the result record,
// the sequencer states and the multiplier request/response bundles.
// ----------------------------------------------------------------------------
package ifk_pkg;

    // coordinate format: signed Q16.16, stiffness unsigned Q16.16
    localparam int CW = 32;
    localparam int FB = 16;
    // force Q24.24, energy Q31.32 (63 bits), reaction Q32.32
    localparam int FW = 48;
    localparam int FMW = FW - 1;
    localparam int EW = 63;
    localparam int RW = 64;
    // penetration depth, its square and cube
    localparam int MW = CW + 1;
    localparam int M2W = 2 * MW;
    localparam int M3W = 3 * MW;
    // serial multiplier operands and accumulator
    localparam int MA_W = M3W;
    localparam int MB_W = MW;
    localparam int MP_W = M3W + 2;
    localparam int THR_W = 7;
    // result shifts
    localparam int F_SHIFT = 3 * FB - 24;
    localparam int E_SHIFT = 4 * FB - 32;
    // divider: numerator is fmag * |d|, quotient below 2^FW
    localparam int NUM_W = FMW + CW;
    localparam int DIV_STEPS = FW;
    // saturation thresholds for the serial multiplier (product >= 2^thr)
    localparam logic [THR_W-1:0] THR_NONE = THR_W'(MP_W - 1);
    localparam logic [THR_W-1:0] THR_F = THR_W'(F_SHIFT + FMW);
    localparam logic [THR_W-1:0] THR_E = THR_W'(E_SHIFT + EW);
    localparam logic [FMW-1:0] FMAX = '1;
    localparam logic [EW-1:0] EMAX = '1;
    // floor(k/3) = (k * RECIP3) >> 33
    localparam logic [CW-1:0] RECIP3 = 32'hAAAA_AAAB;
    localparam int K3_SHIFT = 33;
    localparam int K3W = 2 * CW - K3_SHIFT;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_STYLE  = 3'd0,
        CFG_SIDE   = 3'd1,
        CFG_AXIS   = 3'd2,
        CFG_CX     = 3'd3,
        CFG_CY     = 3'd4,
        CFG_CZ     = 3'd5,
        CFG_RADIUS = 3'd6,
        CFG_STIFF  = 3'd7
    } t_cfg_idx;

    localparam logic [1:0] STY_SPHERE = 2'd0;
    localparam logic [1:0] STY_CYL    = 2'd1;
    localparam logic [1:0] STY_PLANE  = 2'd2;
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    typedef struct packed {
        logic [1:0]           style;
        logic                 side;
        logic [1:0]           axis;
        logic [2:0][CW-1:0]   center;
        logic signed [CW-1:0] radius;
        logic [CW-1:0]        stiff;
    } t_cfg;

    // classified request handed from front to back
    typedef struct packed {
        logic [2:0][CW-1:0] ad;
        logic [2:0]         dneg;
        logic               in_group;
        logic               clear;
        logic               plane_hit;
        logic [MW-1:0]      plane_m;
    } t_item;

    typedef struct packed {
        logic [2:0][FW-1:0] frc;
        logic               contact;
        logic [EW-1:0]      energy;
        logic [2:0][RW-1:0] reac;
    } t_res;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_SQ,
        BS_SQRT,
        BS_CMP,
        BS_MGO,
        BS_MWAIT,
        BS_DIV,
        BS_FIN
    } t_bstate;

    typedef enum logic [2:0] {
        MOP_M2,
        MOP_F,
        MOP_M3,
        MOP_E,
        MOP_N
    } t_mop;

    typedef struct packed {
        logic             start;
        logic [MA_W-1:0]  a;
        logic [MB_W-1:0]  b;
        logic [THR_W-1:0] thr;
    } t_mul_req;

    typedef struct packed {
        logic            done;
        logic [MP_W-1:0] prod;
        logic            big;
    } t_mul_rsp;

    // axis code 3 behaves as z
    function automatic logic [1:0] axis_norm(input logic [1:0] axis);
        return (axis == 2'd3) ? AX_Z : axis;
    endfunction

endpackage

### hw/rtl/ifk_fifo.sv
// ----------------------------------------------------------------------------
// ifk_fifo: small register queue
// Push/pop queue with full and empty flags; data is taken from the head.
// ----------------------------------------------------------------------------
module ifk_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNW-1:0]   r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

### hw/rtl/ifk_front.sv
// ----------------------------------------------------------------------------
// ifk_front: request intake and classification
// Takes one particle, forms the minimum-image deltas and their magnitudes,
// resolves plane contact, and hands the request to the back queue.
// ----------------------------------------------------------------------------
module ifk_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ifk_pkg::t_cfg             i_cfg,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic [ifk_pkg::CW-1:0]    i_pos_x,
    input  logic [ifk_pkg::CW-1:0]    i_pos_y,
    input  logic [ifk_pkg::CW-1:0]    i_pos_z,
    input  logic                      i_in_group,
    input  logic                      i_clear_totals,
    output logic                      o_q_push,
    output ifk_pkg::t_item            o_q_item,
    input  logic                      i_q_full
);
    logic                        r_vld;
    ifk_pkg::t_item              r_item;
    ifk_pkg::t_item              w_item;
    logic                        w_accept;
    logic [2:0][ifk_pkg::CW-1:0] w_pos;
    logic [ifk_pkg::CW-1:0]      w_d;
    logic [1:0]                  w_ax;
    logic [ifk_pkg::CW-1:0]      w_p;
    logic signed [ifk_pkg::MW-1:0] w_pd;
    logic signed [ifk_pkg::MW-1:0] w_npd;

    assign w_pos    = {i_pos_z, i_pos_y, i_pos_x};
    assign w_ax     = ifk_pkg::axis_norm(i_cfg.axis);
    assign o_full   = r_vld && i_q_full;
    assign w_accept = i_push && !o_full;
    assign o_q_push = r_vld && !i_q_full;
    assign o_q_item = r_item;

    // plane penetration along the normal axis
    always_comb begin
        case (w_ax)
            ifk_pkg::AX_X: w_p = i_pos_x;
            ifk_pkg::AX_Y: w_p = i_pos_y;
            default:       w_p = i_pos_z;
        endcase
    end
    assign w_pd  = $signed({w_p[ifk_pkg::CW-1], w_p})
                 - $signed({i_cfg.radius[ifk_pkg::CW-1], i_cfg.radius});
    assign w_npd = -w_pd;

    // wrapped deltas and magnitudes; the cylinder axis drops out
    always_comb begin
        w_item = '0;
        w_d    = '0;
        for (int i = 0; i < 3; i++) begin
            w_d = w_pos[i] - i_cfg.center[i];
            if (!(i_cfg.style == ifk_pkg::STY_CYL && w_ax == 2'(i))) begin
                w_item.dneg[i] = w_d[ifk_pkg::CW-1];
                w_item.ad[i]   = w_d[ifk_pkg::CW-1] ? (~w_d + 1'b1) : w_d;
            end
        end
        w_item.in_group = i_in_group;
        w_item.clear    = i_clear_totals;
        if (i_cfg.side) begin
            w_item.plane_hit = (w_pd > 0);
            w_item.plane_m   = w_pd;
        end else begin
            w_item.plane_hit = (w_pd < 0);
            w_item.plane_m   = w_npd;
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_accept || (r_vld && i_q_full);
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_item;
        end
    end
endmodule

### hw/rtl/ifk_mul.sv
// ----------------------------------------------------------------------------
// ifk_mul: serial saturating multiplier
// Shift-add multiply, one multiplier bit per cycle, most significant first.
// A sticky flag reports a product at or above 2^thr.
// ----------------------------------------------------------------------------
module ifk_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ifk_pkg::t_mul_req i_req,
    output ifk_pkg::t_mul_rsp o_rsp
);
    localparam int CNTW = $clog2(ifk_pkg::MB_W);

    logic                      r_busy, r_done, r_big;
    logic [CNTW-1:0]           r_cnt;
    logic [ifk_pkg::MP_W-1:0]  r_acc, r_mask;
    logic [ifk_pkg::MA_W-1:0]  r_a;
    logic [ifk_pkg::MB_W-1:0]  r_b;
    logic [ifk_pkg::MP_W-1:0]  w_nacc;

    assign w_nacc = {r_acc[ifk_pkg::MP_W-2:0], 1'b0}
                  + (r_b[ifk_pkg::MB_W-1] ? ifk_pkg::MP_W'(r_a) : '0);

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;
    assign o_rsp.big  = r_big;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNTW'(1);
                if (r_cnt == CNTW'(ifk_pkg::MB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_acc  <= '0;
            r_big  <= 1'b0;
            r_mask <= {ifk_pkg::MP_W{1'b1}} << i_req.thr;
        end else if (r_busy) begin
            r_acc <= w_nacc;
            r_b   <= r_b << 1;
            r_big <= r_big || ((w_nacc & r_mask) != '0);
        end
    end
endmodule

### hw/rtl/ifk_back.sv
// ----------------------------------------------------------------------------
// ifk_back: force sequencer
// Runs radius square root and per-axis force division (sphere, cylinder),
// penetration, force and energy products and saturating totals per request.
// ----------------------------------------------------------------------------
module ifk_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ifk_pkg::t_cfg     i_cfg,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  ifk_pkg::t_item    i_q_item,
    output ifk_pkg::t_mul_req o_mul_req,
    input  ifk_pkg::t_mul_rsp i_mul_rsp,
    output logic              o_res_push,
    input  logic              i_res_full,
    output ifk_pkg::t_res     o_res
);
    localparam int CW = ifk_pkg::CW;

    // control state
    ifk_pkg::t_bstate r_state, n_state;
    ifk_pkg::t_mop    r_mop, n_mop;
    logic [5:0]       r_cnt, n_cnt;
    logic [1:0]       r_lane, n_lane;
    logic             r_contact, n_contact;
    logic [ifk_pkg::EW-1:0]      r_energy, n_energy;
    logic [2:0][ifk_pkg::RW-1:0] r_reac, n_reac;

    // working registers
    ifk_pkg::t_item              r_item, n_item;
    logic [2*CW-1:0]             r_r2, n_r2, r_prod, n_prod;
    logic [CW+1:0]               r_srem, n_srem;
    logic [CW-1:0]               r_root, n_root;
    logic [ifk_pkg::MW-1:0]      r_m, n_m;
    logic [ifk_pkg::M2W-1:0]     r_m2, n_m2;
    logic [ifk_pkg::M3W-1:0]     r_m3, n_m3;
    logic [ifk_pkg::FMW-1:0]     r_fmag, n_fmag;
    logic [2:0][ifk_pkg::FW-1:0] r_frc, n_frc;
    logic [CW-1:0]               r_drem, n_drem;
    logic [ifk_pkg::FW-1:0]      r_dnum, n_dnum, r_quo, n_quo;
    logic [ifk_pkg::K3W-1:0]     r_k3;

    // temporaries
    logic [2*CW-1:0]             w_k3_prod;
    logic [CW-1:0]               w_sq_sel;
    logic [CW+3:0]               w_trem, w_trial;
    logic signed [CW+1:0]        w_rr, w_rad, w_dout, w_din;
    logic [ifk_pkg::EW-1:0]      w_e;
    logic [ifk_pkg::EW:0]        w_esum;
    logic [CW:0]                 w_dt;
    logic                        w_ge;
    logic [ifk_pkg::FW-1:0]      w_mag;
    logic [ifk_pkg::FW-1:0]      w_fplane;
    logic [1:0]                  w_ax;
    logic [2:0][ifk_pkg::RW-1:0] w_reac_new;
    logic [ifk_pkg::RW:0]        w_rsum;
    logic [ifk_pkg::RW-1:0]      w_rdel;

    assign w_ax      = ifk_pkg::axis_norm(i_cfg.axis);
    assign w_k3_prod = i_cfg.stiff * ifk_pkg::RECIP3;

    // square-root step: bring down two bits of r^2
    assign w_trem  = {r_srem, r_r2[2*CW-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};

    // radius against indenter size
    assign w_rr   = $signed({2'b00, r_root});
    assign w_rad  = $signed({{2{i_cfg.radius[CW-1]}}, i_cfg.radius});
    assign w_dout = w_rr - w_rad;
    assign w_din  = w_rad - w_rr;

    // energy increment and saturating energy total
    assign w_e    = i_mul_rsp.big ? ifk_pkg::EMAX
                  : i_mul_rsp.prod[ifk_pkg::E_SHIFT +: ifk_pkg::EW];
    assign w_esum = {1'b0, r_energy} + {1'b0, w_e};

    // restoring division step
    assign w_dt  = {r_drem, r_dnum[ifk_pkg::FW-1]};
    assign w_ge  = (w_dt >= {1'b0, r_root});
    assign w_mag = {r_quo[ifk_pkg::FW-2:0], w_ge};

    assign w_fplane = i_cfg.side ? -{1'b0, r_fmag} : {1'b0, r_fmag};

    // square operand per axis
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    w_sq_sel = r_item.ad[0];
            2'd1:    w_sq_sel = r_item.ad[1];
            2'd2:    w_sq_sel = r_item.ad[2];
            default: w_sq_sel = '0;
        endcase
    end

    // reaction totals less force * 256, saturating
    always_comb begin
        w_reac_new = r_reac;
        w_rsum     = '0;
        w_rdel     = '0;
        for (int i = 0; i < 3; i++) begin
            w_rdel = -{{(ifk_pkg::RW-ifk_pkg::FW-8){r_frc[i][ifk_pkg::FW-1]}},
                       r_frc[i], 8'd0};
            w_rsum = {r_reac[i][ifk_pkg::RW-1], r_reac[i]}
                   + {w_rdel[ifk_pkg::RW-1], w_rdel};
            if (w_rsum[ifk_pkg::RW] != w_rsum[ifk_pkg::RW-1]) begin
                w_reac_new[i] = w_rsum[ifk_pkg::RW] ? {1'b1, {(ifk_pkg::RW-1){1'b0}}}
                                                   : {1'b0, {(ifk_pkg::RW-1){1'b1}}};
            end else begin
                w_reac_new[i] = w_rsum[ifk_pkg::RW-1:0];
            end
        end
    end

    // multiplier operands
    always_comb begin
        o_mul_req       = '0;
        o_mul_req.start = (r_state == ifk_pkg::BS_MGO);
        case (r_mop)
            ifk_pkg::MOP_M2: begin
                o_mul_req.a   = ifk_pkg::MA_W'(r_m);
                o_mul_req.b   = r_m;
                o_mul_req.thr = ifk_pkg::THR_NONE;
            end
            ifk_pkg::MOP_F: begin
                o_mul_req.a   = ifk_pkg::MA_W'(r_m2);
                o_mul_req.b   = ifk_pkg::MB_W'(i_cfg.stiff);
                o_mul_req.thr = ifk_pkg::THR_F;
            end
            ifk_pkg::MOP_M3: begin
                o_mul_req.a   = ifk_pkg::MA_W'(r_m2);
                o_mul_req.b   = r_m;
                o_mul_req.thr = ifk_pkg::THR_NONE;
            end
            ifk_pkg::MOP_E: begin
                o_mul_req.a   = r_m3;
                o_mul_req.b   = ifk_pkg::MB_W'(r_k3);
                o_mul_req.thr = ifk_pkg::THR_E;
            end
            default: begin
                o_mul_req.a   = ifk_pkg::MA_W'(r_fmag);
                o_mul_req.b   = ifk_pkg::MB_W'(r_item.ad[r_lane]);
                o_mul_req.thr = ifk_pkg::THR_NONE;
            end
        endcase
    end

    // result record
    always_comb begin
        o_res.frc     = r_frc;
        o_res.contact = r_contact;
        o_res.energy  = r_energy;
        o_res.reac    = w_reac_new;
    end

    // next state and outputs
    always_comb begin
        n_state    = r_state;
        n_mop      = r_mop;
        n_cnt      = r_cnt;
        n_lane     = r_lane;
        n_contact  = r_contact;
        n_energy   = r_energy;
        n_reac     = r_reac;
        n_item     = r_item;
        n_r2       = r_r2;
        n_prod     = r_prod;
        n_srem     = r_srem;
        n_root     = r_root;
        n_m        = r_m;
        n_m2       = r_m2;
        n_m3       = r_m3;
        n_fmag     = r_fmag;
        n_frc      = r_frc;
        n_drem     = r_drem;
        n_dnum     = r_dnum;
        n_quo      = r_quo;
        o_q_pop    = 1'b0;
        o_res_push = 1'b0;
        case (r_state)
            ifk_pkg::BS_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop   = 1'b1;
                    n_item    = i_q_item;
                    n_frc     = '0;
                    n_contact = 1'b0;
                    n_mop     = ifk_pkg::MOP_M2;
                    if (i_q_item.clear) begin
                        n_energy = '0;
                        n_reac   = '0;
                    end
                    if (!i_q_item.in_group) begin
                        n_state = ifk_pkg::BS_FIN;
                    end else if (i_cfg.style[1]) begin
                        n_contact = i_q_item.plane_hit;
                        n_m       = i_q_item.plane_m;
                        n_state   = i_q_item.plane_hit ? ifk_pkg::BS_MGO
                                                       : ifk_pkg::BS_FIN;
                    end else begin
                        n_r2    = '0;
                        n_cnt   = '0;
                        n_state = ifk_pkg::BS_SQ;
                    end
                end
            end
            ifk_pkg::BS_SQ: begin
                n_prod = w_sq_sel * w_sq_sel;
                if (r_cnt != '0) begin
                    n_r2 = r_r2 + r_prod;
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd3) begin
                    n_cnt   = '0;
                    n_srem  = '0;
                    n_root  = '0;
                    n_state = ifk_pkg::BS_SQRT;
                end
            end
            ifk_pkg::BS_SQRT: begin
                if (w_trem >= w_trial) begin
                    n_srem = (CW+2)'(w_trem - w_trial);
                    n_root = {r_root[CW-2:0], 1'b1};
                end else begin
                    n_srem = w_trem[CW+1:0];
                    n_root = {r_root[CW-2:0], 1'b0};
                end
                n_r2  = r_r2 << 2;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(CW - 1)) begin
                    n_state = ifk_pkg::BS_CMP;
                end
            end
            ifk_pkg::BS_CMP: begin
                if (i_cfg.side) begin
                    n_contact = (w_din > 0);
                    n_m       = w_din[ifk_pkg::MW-1:0];
                end else begin
                    n_contact = (w_dout > 0);
                    n_m       = w_dout[ifk_pkg::MW-1:0];
                end
                n_state = n_contact ? ifk_pkg::BS_MGO : ifk_pkg::BS_FIN;
            end
            ifk_pkg::BS_MGO: begin
                n_state = ifk_pkg::BS_MWAIT;
            end
            ifk_pkg::BS_MWAIT: begin
                if (i_mul_rsp.done) begin
                    n_state = ifk_pkg::BS_MGO;
                    case (r_mop)
                        ifk_pkg::MOP_M2: begin
                            n_m2  = i_mul_rsp.prod[ifk_pkg::M2W-1:0];
                            n_mop = ifk_pkg::MOP_F;
                        end
                        ifk_pkg::MOP_F: begin
                            n_fmag = i_mul_rsp.big ? ifk_pkg::FMAX
                                   : i_mul_rsp.prod[ifk_pkg::F_SHIFT +: ifk_pkg::FMW];
                            n_mop  = ifk_pkg::MOP_M3;
                        end
                        ifk_pkg::MOP_M3: begin
                            n_m3  = i_mul_rsp.prod[ifk_pkg::M3W-1:0];
                            n_mop = ifk_pkg::MOP_E;
                        end
                        ifk_pkg::MOP_E: begin
                            n_energy = w_esum[ifk_pkg::EW] ? ifk_pkg::EMAX
                                                           : w_esum[ifk_pkg::EW-1:0];
                            if (i_cfg.style[1]) begin
                                n_frc[w_ax] = w_fplane;
                                n_state     = ifk_pkg::BS_FIN;
                            end else if (r_root == '0) begin
                                n_state = ifk_pkg::BS_FIN;
                            end else begin
                                n_lane = '0;
                                n_mop  = ifk_pkg::MOP_N;
                            end
                        end
                        default: begin
                            n_drem  = CW'(i_mul_rsp.prod[ifk_pkg::NUM_W-1:ifk_pkg::FW]);
                            n_dnum  = i_mul_rsp.prod[ifk_pkg::FW-1:0];
                            n_quo   = '0;
                            n_cnt   = '0;
                            n_state = ifk_pkg::BS_DIV;
                        end
                    endcase
                end
            end
            ifk_pkg::BS_DIV: begin
                n_drem = w_ge ? CW'(w_dt - {1'b0, r_root}) : w_dt[CW-1:0];
                n_dnum = r_dnum << 1;
                n_quo  = w_mag;
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'(ifk_pkg::DIV_STEPS - 1)) begin
                    n_frc[r_lane] = (r_item.dneg[r_lane] ^ !i_cfg.side) ? -w_mag : w_mag;
                    if (r_lane == 2'd2) begin
                        n_state = ifk_pkg::BS_FIN;
                    end else begin
                        n_lane  = r_lane + 2'd1;
                        n_state = ifk_pkg::BS_MGO;
                    end
                end
            end
            ifk_pkg::BS_FIN: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_reac     = w_reac_new;
                    n_state    = ifk_pkg::BS_IDLE;
                end
            end
            default: begin
                n_state = ifk_pkg::BS_IDLE;
            end
        endcase
    end

    // control and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ifk_pkg::BS_IDLE;
            r_mop     <= ifk_pkg::MOP_M2;
            r_cnt     <= '0;
            r_lane    <= '0;
            r_contact <= 1'b0;
            r_energy  <= '0;
            r_reac    <= '0;
        end else begin
            r_state   <= n_state;
            r_mop     <= n_mop;
            r_cnt     <= n_cnt;
            r_lane    <= n_lane;
            r_contact <= n_contact;
            r_energy  <= n_energy;
            r_reac    <= n_reac;
        end
    end

    // working datapath
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_r2   <= n_r2;
        r_prod <= n_prod;
        r_srem <= n_srem;
        r_root <= n_root;
        r_m    <= n_m;
        r_m2   <= n_m2;
        r_m3   <= n_m3;
        r_fmag <= n_fmag;
        r_frc  <= n_frc;
        r_drem <= n_drem;
        r_dnum <= n_dnum;
        r_quo  <= n_quo;
        r_k3   <= w_k3_prod[2*CW-1:ifk_pkg::K3_SHIFT];
    end
endmodule

### hw/rtl/indenter_force_kernel.sv
// ----------------------------------------------------------------------------
// indenter_force_kernel: repulsive indenter force on one particle per request
// Sphere, axis-aligned cylinder or plane indenter with running energy and
// reaction totals, in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter as a queue: push a position while full is low. Results
//   leave as a queue: while empty is low the oldest result is on the o_
//   ports, and pop takes it. Configuration is written through i_cfg_we /
//   i_cfg_addr / i_cfg_wdata while no request is in flight.
//   A request is registered in the intake stage, then waits in the
//   request queue for the sequencer. In the sequencer a request out of
//   group, or on a plane out of contact, goes straight to the result;
//   a sphere or cylinder first sums the squared deltas and takes the
//   square root. A request in contact then makes four passes of the
//   shared serial multiplier (start, 33 steps, done), and a sphere or
//   cylinder adds per axis one multiplier pass and a restoring division.
//   Throughput is one request per sequencer run; intake and the request
//   queue keep taking requests meanwhile.
//   Reset clears the queues, the sequencer and the totals and restores the
//   register defaults. A receiver that holds pop low fills the result
//   queue, then the sequencer waits and the request side shows full.
// ----------------------------------------------------------------------------
module indenter_force_kernel #(
    parameter int QUEUE_DEPTH  = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [2:0]                      i_cfg_addr,
    input  logic [ifk_pkg::CW-1:0]          i_cfg_wdata,
    input  logic                            push,
    output logic                            full,
    input  logic signed [ifk_pkg::CW-1:0]   i_pos_x,
    input  logic signed [ifk_pkg::CW-1:0]   i_pos_y,
    input  logic signed [ifk_pkg::CW-1:0]   i_pos_z,
    input  logic                            i_in_group,
    input  logic                            i_clear_totals,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [ifk_pkg::FW-1:0]   o_force_x,
    output logic signed [ifk_pkg::FW-1:0]   o_force_y,
    output logic signed [ifk_pkg::FW-1:0]   o_force_z,
    output logic                            o_in_contact,
    output logic [ifk_pkg::EW-1:0]          o_energy_total,
    output logic signed [ifk_pkg::RW-1:0]   o_reaction_x,
    output logic signed [ifk_pkg::RW-1:0]   o_reaction_y,
    output logic signed [ifk_pkg::RW-1:0]   o_reaction_z
);
    ifk_pkg::t_cfg     r_cfg;
    ifk_pkg::t_item    w_q_in, w_q_out;
    ifk_pkg::t_res     w_res_in, w_res_out;
    ifk_pkg::t_mul_req w_mul_req;
    ifk_pkg::t_mul_rsp w_mul_rsp;
    logic              w_q_push, w_q_full, w_q_pop, w_q_empty;
    logic              w_res_push, w_res_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.style  <= ifk_pkg::STY_SPHERE;
            r_cfg.side   <= 1'b1;
            r_cfg.axis   <= ifk_pkg::AX_Z;
            r_cfg.center <= '0;
            r_cfg.radius <= '0;
            r_cfg.stiff  <= '0;
        end else if (i_cfg_we) begin
            case (ifk_pkg::t_cfg_idx'(i_cfg_addr))
                ifk_pkg::CFG_STYLE:  r_cfg.style     <= i_cfg_wdata[1:0];
                ifk_pkg::CFG_SIDE:   r_cfg.side      <= i_cfg_wdata[0];
                ifk_pkg::CFG_AXIS:   r_cfg.axis      <= i_cfg_wdata[1:0];
                ifk_pkg::CFG_CX:     r_cfg.center[0] <= i_cfg_wdata;
                ifk_pkg::CFG_CY:     r_cfg.center[1] <= i_cfg_wdata;
                ifk_pkg::CFG_CZ:     r_cfg.center[2] <= i_cfg_wdata;
                ifk_pkg::CFG_RADIUS: r_cfg.radius    <= i_cfg_wdata;
                ifk_pkg::CFG_STIFF:  r_cfg.stiff     <= i_cfg_wdata;
                default:             r_cfg.stiff     <= r_cfg.stiff;
            endcase
        end
    end

    // intake and classification
    ifk_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .o_full         (full),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_in_group     (i_in_group),
        .i_clear_totals (i_clear_totals),
        .o_q_push       (w_q_push),
        .o_q_item       (w_q_in),
        .i_q_full       (w_q_full)
    );

    // request queue between intake and sequencer
    ifk_fifo #(
        .WIDTH ($bits(ifk_pkg::t_item)),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    // force sequencer
    ifk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .i_q_item   (w_q_out),
        .o_mul_req  (w_mul_req),
        .i_mul_rsp  (w_mul_rsp),
        .o_res_push (w_res_push),
        .i_res_full (w_res_full),
        .o_res      (w_res_in)
    );

    // shared serial multiplier
    ifk_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    // result queue
    ifk_fifo #(
        .WIDTH ($bits(ifk_pkg::t_res)),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_force_x      = w_res_out.frc[0];
    assign o_force_y      = w_res_out.frc[1];
    assign o_force_z      = w_res_out.frc[2];
    assign o_in_contact   = w_res_out.contact;
    assign o_energy_total = w_res_out.energy;
    assign o_reaction_x   = w_res_out.reac[0];
    assign o_reaction_y   = w_res_out.reac[1];
    assign o_reaction_z   = w_res_out.reac[2];

    // sequencer never writes a full result queue
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_res_full))
        else $error("result written into full queue");

    // a finished request is visible on the next cycle
    a_res_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |=> !empty)
        else $error("result not visible after write");

    // no contact means no force
    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_in_contact) |->
            (o_force_x == '0 && o_force_y == '0 && o_force_z == '0))
        else $error("force without contact");

    // the sequencer only takes a request from a non-empty queue
    a_req_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> !w_q_empty)
        else $error("request taken from empty queue");
endmodule
